@@ src/ircsu_pkg.sv @@
// ---------------------------------------------------------------------------
// ircsu_pkg
// Shared types and constants of the infrared code symbol unpacker.
// ---------------------------------------------------------------------------
package ircsu_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_TABLE = 2'd1,
      REQ_CODE  = 2'd2
   } req_kind_type;

   // result kinds carried in rsp_tuser
   typedef enum logic [1:0] {
      STAT_DURATION = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_TOO_LONG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_FIRST,
      S_SECOND
   } state_type;

   // configuration register indexes
   localparam logic CSR_BITS_PER_SYMBOL = 1'b0;
   localparam logic CSR_PAIR_COUNT      = 1'b1;

   localparam logic [3:0] BPS_RESET      = 4'd4;
   localparam logic [3:0] BYTE_BITS      = 4'd8;
   localparam logic [3:0] MIN_SYM_WIDTH  = 4'd1;
   localparam logic [3:0] MAX_SYM_WIDTH  = 4'd8;

endpackage

@@ src/ircsu_ram.sv @@
// ---------------------------------------------------------------------------
// ircsu_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ircsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ir_code_symbol_unpacker.sv @@
// ---------------------------------------------------------------------------
// ir_code_symbol_unpacker
// Unpacks MSB-first symbols from code bytes, looks each one up in a timing
// table RAM and emits the pair of durations scaled to microseconds.
// A code byte holds the block from its accept through S_SHIFT for each bit shifted
// in and S_FIRST then S_SECOND for each completed symbol (one per result word),
// shorter when the code ends inside the byte, longer while rsp_tready is low.
// First result of a symbol is read through the single table RAM read port and
// registered in S_FIRST once the output is free. Start and table requests keep S_IDLE.
// Synchronous reset clears control state and config; table contents stay
// undefined until written.
// ---------------------------------------------------------------------------
module ir_code_symbol_unpacker
   import ircsu_pkg::*;
#(
   parameter int MAX_PAIRS   = 256,
   parameter int TABLE_DEPTH = 256,
   parameter int TIME_WIDTH  = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request transactions
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // code_byte, table_index, first_time, second_time
   input  logic [1:0]  req_tuser,  // req_type
   // result transactions
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // duration_us
   output logic [2:0]  rsp_tuser,  // status, pair_half
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [9:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int TW = TIME_WIDTH;

   state_type state_ff, state_in;

   logic [7:0]  held_ff, held_in;
   logic [3:0]  bits_rem_ff, bits_rem_in;
   logic [7:0]  partial_ff, partial_in;
   logic [3:0]  done_ff, done_in;
   logic [9:0]  pairs_left_ff, pairs_left_in;
   logic        oob_ff, oob_in;
   logic [3:0]  bps_ff;
   logic [9:0]  pair_count_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_dur_ff, rsp_dur_in;
   logic        rsp_half_ff, rsp_half_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [7:0]  req_code_byte;
   logic [7:0]  req_table_index;
   logic [15:0] req_first_time;
   logic [15:0] req_second_time;
   logic        req_acc;
   logic        out_free;

   logic [3:0]  sym_width;
   logic [7:0]  partial_shift;
   logic [3:0]  done_inc;
   logic [3:0]  bits_dec;
   logic        sym_done;

   logic          ram_we;
   logic          ram_re;
   logic [2*TW-1:0] ram_wdata;
   logic [2*TW-1:0] ram_rdata;
   logic [TW+15:0]  first_wide;
   logic [TW+15:0]  second_wide;
   logic [TW+15:0]  rd_first_wide;
   logic [TW+15:0]  rd_second_wide;
   logic [15:0]     first_scaled;
   logic [15:0]     second_scaled;

   assign req_code_byte   = req_tdata[7:0];
   assign req_table_index = req_tdata[15:8];
   assign req_first_time  = req_tdata[31:16];
   assign req_second_time = req_tdata[47:32];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;

   // symbol width clamped to 1..8
   always_comb begin
      if (bps_ff == 4'd0) begin
         sym_width = MIN_SYM_WIDTH;
      end else if (bps_ff > MAX_SYM_WIDTH) begin
         sym_width = MAX_SYM_WIDTH;
      end else begin
         sym_width = bps_ff;
      end
   end

   assign partial_shift = {partial_ff[6:0], held_ff[7]};
   assign done_inc      = done_ff + 4'd1;
   assign bits_dec      = bits_rem_ff - 4'd1;
   assign sym_done      = done_inc >= sym_width;

   // table words: stored at TIME_WIDTH bits, scaled by ten modulo 2^16
   assign first_wide     = {{TW{1'b0}}, req_first_time};
   assign second_wide    = {{TW{1'b0}}, req_second_time};
   assign ram_wdata      = {second_wide[TW-1:0], first_wide[TW-1:0]};
   assign rd_first_wide  = {16'd0, ram_rdata[TW-1:0]};
   assign rd_second_wide = {16'd0, ram_rdata[2*TW-1:TW]};
   assign first_scaled   = 16'({rd_first_wide[15:0], 3'b000} + {3'b000, rd_first_wide[15:0], 1'b0});
   assign second_scaled  = 16'({rd_second_wide[15:0], 3'b000} + {3'b000, rd_second_wide[15:0], 1'b0});

   ircsu_ram #(
      .WIDTH (2 * TW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_table_index[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (partial_shift[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && req_tuser == REQ_CODE && pairs_left_ff != 10'd0) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (sym_done) begin
               state_in = S_FIRST;
            end else if (bits_dec == 4'd0) begin
               state_in = S_IDLE;
            end
         end
         S_FIRST: begin
            if (out_free) begin
               state_in = S_SECOND;
            end
         end
         S_SECOND: begin
            if (out_free) begin
               if (pairs_left_ff == 10'd0 || bits_rem_ff == 4'd0) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      held_in       = held_ff;
      bits_rem_in   = bits_rem_ff;
      partial_in    = partial_ff;
      done_in       = done_ff;
      pairs_left_in = pairs_left_ff;
      oob_in        = oob_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_dur_in    = rsp_dur_ff;
      rsp_half_in   = rsp_half_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_tuser)
                  REQ_START: begin
                     held_in       = 8'd0;
                     bits_rem_in   = 4'd0;
                     partial_in    = 8'd0;
                     done_in       = 4'd0;
                     pairs_left_in = 10'd0;
                     if (pair_count_ff > 10'(MAX_PAIRS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_TOO_LONG;
                        rsp_dur_in    = 16'd0;
                        rsp_half_in   = 1'b0;
                        rsp_last_in   = 1'b1;
                     end else if (pair_count_ff == 10'd0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_dur_in    = 16'd0;
                        rsp_half_in   = 1'b0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        pairs_left_in = pair_count_ff;
                     end
                  end
                  REQ_TABLE: begin
                     ram_we = {1'b0, req_table_index} < 9'(TABLE_DEPTH);
                  end
                  REQ_CODE: begin
                     if (pairs_left_ff != 10'd0) begin
                        held_in     = req_code_byte;
                        bits_rem_in = BYTE_BITS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SHIFT: begin
            held_in     = {held_ff[6:0], 1'b0};
            bits_rem_in = bits_dec;
            partial_in  = partial_shift;
            done_in     = done_inc;
            if (sym_done) begin
               ram_re        = 1'b1;
               oob_in        = {1'b0, partial_shift} >= 9'(TABLE_DEPTH);
               partial_in    = 8'd0;
               done_in       = 4'd0;
               pairs_left_in = pairs_left_ff - 10'd1;
            end
         end
         S_FIRST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_DURATION;
               rsp_dur_in    = oob_ff ? 16'd0 : first_scaled;
               rsp_half_in   = 1'b0;
               rsp_last_in   = 1'b0;
            end
         end
         S_SECOND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_DURATION;
               rsp_dur_in    = oob_ff ? 16'd0 : second_scaled;
               rsp_half_in   = 1'b1;
               rsp_last_in   = pairs_left_ff == 10'd0;
               // code finished: drop the rest of the byte
               if (pairs_left_ff == 10'd0) begin
                  bits_rem_in = 4'd0;
                  partial_in  = 8'd0;
                  done_in     = 4'd0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= 8'd0;
         bits_rem_ff   <= 4'd0;
         partial_ff    <= 8'd0;
         done_ff       <= 4'd0;
         pairs_left_ff <= 10'd0;
         oob_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bps_ff        <= BPS_RESET;
         pair_count_ff <= 10'd0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         bits_rem_ff   <= bits_rem_in;
         partial_ff    <= partial_in;
         done_ff       <= done_in;
         pairs_left_ff <= pairs_left_in;
         oob_ff        <= oob_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_BITS_PER_SYMBOL: bps_ff        <= csr_wdata[3:0];
               CSR_PAIR_COUNT:      pair_count_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_dur_ff    <= rsp_dur_in;
      rsp_half_ff   <= rsp_half_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dur_ff;
   assign rsp_tuser  = {rsp_half_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // status results always close a code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_DURATION |-> rsp_last_ff && !rsp_half_ff)
      else $error("status result without last");

   // last duration word is the second half of a pair
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && rsp_status_ff == STAT_DURATION |-> rsp_half_ff)
      else $error("last on first half of a pair");

   // shifting only with bits left and a code armed
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> bits_rem_ff != 4'd0 && pairs_left_ff != 10'd0)
      else $error("shift with no bits or no pairs left");

   // a partial symbol stays below the maximum width and pairs left within MAX_PAIRS
   assert property (@(posedge clock) disable iff (reset)
      done_ff < MAX_SYM_WIDTH && pairs_left_ff <= 10'(MAX_PAIRS))
      else $error("symbol bit count or pair count out of range");

   // the table read issued at symbol end feeds the next two result words
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT && sym_done |=> state_ff == S_FIRST)
      else $error("symbol completion did not start emission");
`endif

endmodule
